// File: hdl/assert_macros.svh
// Shared concurrent assertion shorthands
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/ppfs_pkg.sv
package ppfs_pkg;

   localparam int CELLS   = 512;
   localparam int WINDING = 1;
   localparam int IDX_W   = $clog2(CELLS);

   localparam int CMD_W   = 2;
   localparam int CELL_W  = 9;
   localparam int Q_W     = 32;
   localparam int PHASE_W = 24;
   localparam int CSR_W   = 3;
   localparam int SIN_W   = 18;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [CSR_W-1:0] CSR_TIME_STEP  = 3'd0;
   localparam logic [CSR_W-1:0] CSR_MOB_STRAIN = 3'd1;
   localparam logic [CSR_W-1:0] CSR_MOB_PHASE  = 3'd2;
   localparam logic [CSR_W-1:0] CSR_GRAD       = 3'd3;
   localparam logic [CSR_W-1:0] CSR_REST_LEN   = 3'd4;
   localparam logic [CSR_W-1:0] CSR_REST_AMP   = 3'd5;
   localparam logic [CSR_W-1:0] CSR_TILT_AMP   = 3'd6;
   localparam logic [CSR_W-1:0] CSR_DRIVE      = 3'd7;

   localparam longint HALF_PI_Q30  = 64'sd1686629713;
   localparam longint TURN_PER_RAD = 64'sd683565276;
   localparam logic [PHASE_W-1:0] QUARTER_TURN = 24'h400000;

   localparam int QUARTER_PTS = 1025;
   typedef logic [16:0] quarter_table_type [0:QUARTER_PTS-1];

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return 32'sh7fffffff;
      if (v < -64'sd2147483648)
         return 32'sh80000000;
      return v[Q_W-1:0];
   endfunction

   // Q16.16 product, round half up, floor shift
   function automatic logic signed [Q_W-1:0] qmul(input logic signed [Q_W-1:0] a,
                                                  input logic signed [Q_W-1:0] b);
      longint aa;
      longint bb;
      aa = a;
      bb = b;
      return sat32((aa * bb + 64'sd32768) >>> 16);
   endfunction

   function automatic logic signed [Q_W-1:0] lap3(input logic signed [Q_W-1:0] m,
                                                  input logic signed [Q_W-1:0] c,
                                                  input logic signed [Q_W-1:0] p);
      longint mm;
      longint cc;
      longint pp;
      mm = m;
      cc = c;
      pp = p;
      return sat32(mm + pp - 2 * cc);
   endfunction

   // nonnegative series term over (2n)(2n+1), exact through a 2^-64 reciprocal
   function automatic longint taylor_div(input longint term, input int n);
      logic [63:0]  recip;
      logic [127:0] prod;
      case (n)
         1:       recip = 64'd3074457345618258603;
         2:       recip = 64'd922337203685477581;
         3:       recip = 64'd439208192231179801;
         4:       recip = 64'd256204778801521551;
         default: recip = 64'd167697673397359561;
      endcase
      prod = 128'(term) * 128'(recip);
      return longint'(prod[127:64]);
   endfunction

   // Quarter wave in Q16, Taylor series to x^11 in Q30
   function automatic quarter_table_type build_quarter();
      quarter_table_type t;
      longint x;
      longint x2;
      longint term;
      longint sum;
      for (int r = 0; r < QUARTER_PTS; r++) begin
         x = (longint'(r) * HALF_PI_Q30) >>> 10;
         x2 = (x * x) >>> 30;
         term = x;
         sum = x;
         for (int n = 1; n <= 5; n++) begin
            term = (term * x2) >>> 30;
            term = taylor_div(term, n);
            if (n[0])
               sum = sum - term;
            else
               sum = sum + term;
         end
         if (sum < 0)
            sum = 0;
         t[r] = 17'((sum + 8192) >>> 14);
      end
      return t;
   endfunction

endpackage

// File: hdl/periodic_phase_field_stencil_step.sv
// channel  | dir | handshake           | payload
// req      | in  | req_valid/req_stall | command, cell_index, strain_in, phase_in
// rsp      | out | rsp_valid/rsp_stall | cell_out, strain_out, phase_out
// csr      | in  | csr_write           | csr_index, csr_data
// A load writes the ring memories when it is accepted; a read waits while the previous response sits stalled.
// A step runs S_INIT, then a potential pass and an update pass over every cell: per cell
// S_RD_M..S_POT in the potential pass and S_RD_M..S_WB in the update pass, sequenced by
// the single read port of each ring memory, which fetches one neighbour per state.
// Synchronous reset restores the coefficients; the ring memories are not cleared.
// req_stall is high while a step or read is in flight.
module periodic_phase_field_stencil_step (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ppfs_pkg::CMD_W-1:0]          req_command,
   input  logic [ppfs_pkg::CELL_W-1:0]         req_cell_index,
   input  logic signed [ppfs_pkg::Q_W-1:0]     req_strain_in,
   input  logic [ppfs_pkg::PHASE_W-1:0]        req_phase_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [ppfs_pkg::CELL_W-1:0]         rsp_cell_out,
   output logic signed [ppfs_pkg::Q_W-1:0]     rsp_strain_out,
   output logic [ppfs_pkg::PHASE_W-1:0]        rsp_phase_out,
   input  logic                                csr_write,
   input  logic [ppfs_pkg::CSR_W-1:0]          csr_index,
   input  logic [ppfs_pkg::Q_W-1:0]            csr_data
);
   import ppfs_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_INIT, S_RD_M, S_RD_C, S_RD_P, S_LAP, S_COS,
      S_SPRING, S_POT, S_DELL, S_FORCE, S_DF, S_RATE, S_RAD, S_WB
   } state_type;

   state_type state_ff;

   logic [30:0] time_step_ff, mob_strain_ff, mob_phase_ff, grad_ff;
   logic signed [Q_W-1:0] rest_len_ff, rest_amp_ff, tilt_amp_ff, drive_ff;

   logic signed [Q_W-1:0] strain_ram_ff [0:CELLS-1];
   logic [PHASE_W-1:0]    phase_ram_ff  [0:CELLS-1];
   logic signed [Q_W-1:0] pot_ram_ff    [0:CELLS-1];

   logic signed [Q_W-1:0] strain_q_ff, pot_q_ff;
   logic [PHASE_W-1:0]    phase_q_ff;

   logic [IDX_W-1:0] idx_ff, im, ip, rd_addr, wr_addr;
   logic             pass_ff;
   logic [CELL_W-1:0] cell_ff;

   logic signed [Q_W-1:0] nb_m_ff, nb_c_ff, lap_ff, strain_c_ff, t_ff, spring_ff;
   logic signed [Q_W-1:0] a_ff, rate_l_ff, tilt_ff;
   logic signed [SIN_W-1:0] sinf_ff, sinmf_ff;
   logic [PHASE_W-1:0] phase_c_ff;

   logic signed [Q_W-1:0] rsp_strain_ff;
   logic [PHASE_W-1:0]    rsp_phase_ff;
   logic [CELL_W-1:0]     rsp_cell_ff;
   logic                  rsp_valid_ff;

   logic req_acc, in_ring, rsp_free, cell_last;
   logic signed [Q_W-1:0] neigh_q, strain_wd, pot_wd;
   logic [PHASE_W-1:0] phase_wd, rom_angle, mf;
   logic signed [SIN_W-1:0] sine;
   logic strain_we, phase_we, pot_we;
   logic signed [63:0] turn_prod;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign in_ring   = (32'(req_cell_index) < CELLS);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign cell_last = (idx_ff == IDX_W'(CELLS - 1));
   assign im        = (idx_ff == '0) ? IDX_W'(CELLS - 1) : idx_ff - 1'b1;
   assign ip        = cell_last ? '0 : idx_ff + 1'b1;
   assign neigh_q   = pass_ff ? pot_q_ff : strain_q_ff;
   assign mf        = 24'({8'd0, phase_c_ff} * 32'(WINDING));

   always_comb begin
      case (state_ff)
         S_IDLE:  rd_addr = IDX_W'(req_cell_index);
         S_READ:  rd_addr = IDX_W'(cell_ff);
         S_RD_M:  rd_addr = im;
         S_RD_C:  rd_addr = idx_ff;
         default: rd_addr = ip;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_LAP:   rom_angle = phase_c_ff + QUARTER_TURN;
         S_COS:   rom_angle = phase_c_ff;
         default: rom_angle = mf;
      endcase
   end

   ppfs_sine_rom u_sine (
      .clock (clock),
      .angle (rom_angle),
      .sine  (sine)
   );

   assign turn_prod = (longint'(a_ff) * TURN_PER_RAD + 64'sd8388608) >>> 24;

   always_comb begin
      strain_we = 1'b0;
      phase_we  = 1'b0;
      pot_we    = 1'b0;
      wr_addr   = idx_ff;
      strain_wd = sat32(longint'(strain_c_ff) + longint'(qmul(rate_l_ff, lap_ff)));
      phase_wd  = phase_c_ff + turn_prod[PHASE_W-1:0];
      pot_wd    = sat32(longint'(spring_ff) - longint'(qmul($signed({1'b0, grad_ff}), lap_ff)));
      if (state_ff == S_IDLE) begin
         wr_addr   = IDX_W'(req_cell_index);
         strain_wd = req_strain_in;
         phase_wd  = req_phase_in;
         strain_we = req_acc && (req_command == CMD_LOAD) && in_ring;
         phase_we  = strain_we;
      end else if (state_ff == S_WB) begin
         strain_we = 1'b1;
         phase_we  = 1'b1;
      end else if (state_ff == S_POT) begin
         pot_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (strain_we)
         strain_ram_ff[wr_addr] <= strain_wd;
      if (phase_we)
         phase_ram_ff[wr_addr] <= phase_wd;
      if (pot_we)
         pot_ram_ff[wr_addr] <= pot_wd;
      strain_q_ff <= strain_ram_ff[rd_addr];
      phase_q_ff  <= phase_ram_ff[rd_addr];
      pot_q_ff    <= pot_ram_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_step_ff  <= 31'd3277;
         mob_strain_ff <= 31'd6554;
         mob_phase_ff  <= 31'd32768;
         grad_ff       <= 31'd32768;
         rest_len_ff   <= 32'sd65536;
         rest_amp_ff   <= 32'sd32768;
         tilt_amp_ff   <= 32'sd19661;
         drive_ff      <= 32'sd13107;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TIME_STEP:  time_step_ff  <= csr_data[30:0];
            CSR_MOB_STRAIN: mob_strain_ff <= csr_data[30:0];
            CSR_MOB_PHASE:  mob_phase_ff  <= csr_data[30:0];
            CSR_GRAD:       grad_ff       <= csr_data[30:0];
            CSR_REST_LEN:   rest_len_ff   <= $signed(csr_data);
            CSR_REST_AMP:   rest_amp_ff   <= $signed(csr_data);
            CSR_TILT_AMP:   tilt_amp_ff   <= $signed(csr_data);
            CSR_DRIVE:      drive_ff      <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pass_ff      <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // S_READ reloads the response register itself
         if (rsp_valid_ff && !rsp_stall && state_ff != S_READ)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cell_ff <= req_cell_index;
                  if (req_command == CMD_STEP)
                     state_ff <= S_INIT;
                  else if (req_command == CMD_READ && in_ring)
                     state_ff <= S_READ;
               end
            end
            S_READ: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_cell_ff   <= cell_ff;
                  rsp_strain_ff <= strain_q_ff;
                  rsp_phase_ff  <= phase_q_ff;
                  state_ff      <= S_IDLE;
               end
            end
            S_INIT: begin
               rate_l_ff <= qmul($signed({1'b0, time_step_ff}), $signed({1'b0, mob_strain_ff}));
               tilt_ff   <= sat32(longint'(tilt_amp_ff) * longint'(WINDING));
               idx_ff    <= '0;
               pass_ff   <= 1'b0;
               state_ff  <= S_RD_M;
            end
            S_RD_M: state_ff <= S_RD_C;
            S_RD_C: begin
               nb_m_ff  <= neigh_q;
               state_ff <= S_RD_P;
            end
            S_RD_P: begin
               nb_c_ff     <= neigh_q;
               strain_c_ff <= strain_q_ff;
               phase_c_ff  <= phase_q_ff;
               state_ff    <= S_LAP;
            end
            S_LAP: begin
               lap_ff   <= lap3(nb_m_ff, nb_c_ff, neigh_q);
               state_ff <= S_COS;
            end
            S_COS: begin
               t_ff     <= qmul(rest_amp_ff, 32'(sine));
               state_ff <= S_SPRING;
            end
            S_SPRING: begin
               spring_ff <= sat32(longint'(strain_c_ff)
                                  - longint'(sat32(longint'(rest_len_ff) + longint'(t_ff))));
               sinf_ff   <= sine;
               state_ff  <= pass_ff ? S_DELL : S_POT;
            end
            S_DELL: begin
               sinmf_ff <= sine;
               a_ff     <= sat32(-longint'(qmul(rest_amp_ff, 32'(sinf_ff))));
               state_ff <= S_FORCE;
            end
            S_FORCE: begin
               a_ff     <= sat32(-longint'(qmul(spring_ff, a_ff)));
               state_ff <= S_DF;
            end
            S_DF: begin
               a_ff     <= sat32(longint'(a_ff) + longint'(qmul(tilt_ff, 32'(sinmf_ff))));
               state_ff <= S_RATE;
            end
            S_RATE: begin
               a_ff <= sat32(longint'(drive_ff)
                             - longint'(qmul($signed({1'b0, mob_phase_ff}), a_ff)));
               state_ff <= S_RAD;
            end
            S_RAD: begin
               a_ff     <= qmul($signed({1'b0, time_step_ff}), a_ff);
               state_ff <= S_WB;
            end
            default: begin
               // S_POT and S_WB finish a cell
               if (!cell_last) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_RD_M;
               end else if (!pass_ff) begin
                  idx_ff   <= '0;
                  pass_ff  <= 1'b1;
                  state_ff <= S_RD_M;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_out   = rsp_cell_ff;
   assign rsp_strain_out = rsp_strain_ff;
   assign rsp_phase_out  = rsp_phase_ff;

endmodule

// File: hdl/ppfs_sine_rom.sv
module ppfs_sine_rom (
   input  logic                              clock,
   input  logic [ppfs_pkg::PHASE_W-1:0]      angle,
   output logic signed [ppfs_pkg::SIN_W-1:0] sine
);
   import ppfs_pkg::*;

   localparam quarter_table_type QUARTER = build_quarter();

   logic [11:0] k;
   logic [10:0] ridx;
   logic [16:0] mag_ff;
   logic        neg_ff;

   assign k    = angle[PHASE_W-1:PHASE_W-12];
   // odd quadrants run the quarter wave backward
   assign ridx = k[10] ? (11'd1024 - {1'b0, k[9:0]}) : {1'b0, k[9:0]};

   always_ff @(posedge clock) begin
      mag_ff <= QUARTER[ridx];
      neg_ff <= k[11];
   end

   assign sine = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});

endmodule

// File: hdl/ppfs_checker.sv
`include "assert_macros.svh"

module ppfs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic [ppfs_pkg::CMD_W-1:0]  req_command,
   input logic [ppfs_pkg::CELL_W-1:0] req_cell_index,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [ppfs_pkg::CELL_W-1:0] rsp_cell_out
);
   import ppfs_pkg::*;

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_cell_out), "stalled response changed")
   `ASSERT_IMPLIES(a_read_rsp, clock, reset, req_acc && req_command == CMD_READ && !rsp_valid, ##2 (rsp_valid && rsp_cell_out == $past(req_cell_index, 2)), "read transaction gave no matching response")
   `ASSERT_NEXT(a_step_busy, clock, reset, req_acc && req_command == CMD_STEP, req_stall, "step did not hold off requests")
   `ASSERT_IMPLIES(a_no_spurious, clock, reset, req_acc && req_command != CMD_READ && !rsp_valid, ##2 !rsp_valid, "response without read transaction")

endmodule

bind periodic_phase_field_stencil_step ppfs_checker u_ppfs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_command    (req_command),
   .req_cell_index (req_cell_index),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_cell_out   (rsp_cell_out)
);

// File: verif/periodic_phase_field_stencil_step_tb.sv
module periodic_phase_field_stencil_step_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ppfs_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam longint CYCLE_LIMIT = 3000000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_command = CMD_LOAD;
   logic [CELL_W-1:0]          req_cell_index = '0;
   logic signed [Q_W-1:0]      req_strain_in = '0;
   logic [PHASE_W-1:0]         req_phase_in = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [CELL_W-1:0]          rsp_cell_out;
   logic signed [Q_W-1:0]      rsp_strain_out;
   logic [PHASE_W-1:0]         rsp_phase_out;
   logic                       csr_write = 1'b0;
   logic [CSR_W-1:0]           csr_index = '0;
   logic [Q_W-1:0]             csr_data = '0;

   periodic_phase_field_stencil_step uut (.*);

   typedef struct {
      logic [CELL_W-1:0]     cell_no;
      logic signed [Q_W-1:0] strain;
      logic [PHASE_W-1:0]    phase;
   } cell_read_type;

   cell_read_type pending_reads[$];

   // predictor state
   longint     ring_strain[CELLS];
   logic [PHASE_W-1:0] ring_phase[CELLS];
   longint     ring_mu[CELLS];
   longint     quarter_sin[0:1024];
   longint     c_dt, c_mob_l, c_mob_f, c_grad, c_rest, c_ramp, c_tilt, c_drive;

   int         errors = 0;
   longint     cycles = 0;
   int         hold_left = 0;
   bit         calm_rx = 1'b0;
   bit         calm_tx = 1'b0;
   int         rx_run = 0;
   bit         rx_busy = 1'b0;

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic longint clip(input longint v);
      if (v > SAT_HI) return SAT_HI;
      if (v < SAT_LO) return SAT_LO;
      return v;
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      return clip((a * b + 64'sd32768) >>> 16);
   endfunction

   function automatic longint sin_turn(input logic [PHASE_W-1:0] ph);
      logic [11:0] k;
      longint s;
      k = ph[23:12];
      s = k[10] ? quarter_sin[1024 - k[9:0]] : quarter_sin[k[9:0]];
      return k[11] ? -s : s;
   endfunction

   function automatic longint rest_len(input logic [PHASE_W-1:0] ph);
      return clip(c_rest + fx_mul(c_ramp, sin_turn(ph + QUARTER_TURN)));
   endfunction

   function automatic longint ring_lap(input longint m, input longint c, input longint p);
      return clip(m + p - 2 * c);
   endfunction

   task automatic fill_sine();
      longint x, x2, term, acc;
      for (int r = 0; r <= 1024; r++) begin
         x = longint'(r) * HALF_PI_Q30 / 1024;
         x2 = (x * x) >>> 30;
         term = x;
         acc = x;
         for (int n = 1; n <= 5; n++) begin
            term = (term * x2) >>> 30;
            term = term / ((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - term : acc + term;
         end
         if (acc < 0) acc = 0;
         quarter_sin[r] = (acc + 8192) >>> 14;
      end
   endtask

   task automatic advance_ring();
      longint rate_l, tilt, spring, dell, dfree, rate, rad, turns;
      logic [PHASE_W-1:0] f;
      int ip, im;
      rate_l = fx_mul(c_dt, c_mob_l);
      tilt = clip(c_tilt * WINDING);
      for (int i = 0; i < CELLS; i++) begin
         ip = (i + 1) % CELLS;
         im = (i + CELLS - 1) % CELLS;
         spring = clip(ring_strain[i] - rest_len(ring_phase[i]));
         ring_mu[i] = clip(spring - fx_mul(c_grad,
            ring_lap(ring_strain[im], ring_strain[i], ring_strain[ip])));
      end
      for (int i = 0; i < CELLS; i++) begin
         ip = (i + 1) % CELLS;
         im = (i + CELLS - 1) % CELLS;
         f = ring_phase[i];
         spring = clip(ring_strain[i] - rest_len(f));
         dell = clip(-fx_mul(c_ramp, sin_turn(f)));
         dfree = clip(clip(-fx_mul(spring, dell)) + fx_mul(tilt, sin_turn(f * WINDING)));
         rate = clip(c_drive - fx_mul(c_mob_f, dfree));
         rad = fx_mul(c_dt, rate);
         turns = (rad * TURN_PER_RAD + 64'sd8388608) >>> 24;
         ring_strain[i] = clip(ring_strain[i]
            + fx_mul(rate_l, ring_lap(ring_mu[im], ring_mu[i], ring_mu[ip])));
         ring_phase[i] = f + turns[PHASE_W-1:0];
      end
   endtask

   // one transaction on req, predictor updated on acceptance
   task automatic send(input logic [CMD_W-1:0] cmd, input int cell_no,
                       input logic [31:0] strain, input logic [PHASE_W-1:0] phase);
      cell_read_type rd;
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= cmd;
      req_cell_index <= cell_no[CELL_W-1:0];
      req_strain_in <= strain;
      req_phase_in <= phase;
      do @(posedge clock); while (req_stall);
      case (cmd)
         CMD_LOAD: begin
            ring_strain[cell_no] = longint'(signed'(strain));
            ring_phase[cell_no] = phase;
         end
         CMD_STEP: advance_ring();
         CMD_READ: begin
            rd.cell_no = cell_no[CELL_W-1:0];
            rd.strain = ring_strain[cell_no][31:0];
            rd.phase = ring_phase[cell_no];
            pending_reads.push_back(rd);
         end
         default: ;
      endcase
   endtask

   task automatic tx_gap();
      int n, p;
      p = $urandom_range(99);
      if (calm_tx || p < 65) return;
      n = (p < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_reads.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
   endtask

   // reads trail a step, so their return proves the block is idle
   task automatic settle();
      send(CMD_READ, $urandom_range(CELLS - 1), $urandom, $urandom);
      drain();
   endtask

   task automatic write_reg(input logic [CSR_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      case (idx)
         CSR_TIME_STEP:  c_dt = val[30:0];
         CSR_MOB_STRAIN: c_mob_l = val[30:0];
         CSR_MOB_PHASE:  c_mob_f = val[30:0];
         CSR_GRAD:       c_grad = val[30:0];
         CSR_REST_LEN:   c_rest = longint'(signed'(val));
         CSR_REST_AMP:   c_ramp = longint'(signed'(val));
         CSR_TILT_AMP:   c_tilt = longint'(signed'(val));
         default:        c_drive = longint'(signed'(val));
      endcase
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] v0, v1, v2, v3, v4, v5, v6, v7);
      write_reg(CSR_TIME_STEP, v0);
      write_reg(CSR_MOB_STRAIN, v1);
      write_reg(CSR_MOB_PHASE, v2);
      write_reg(CSR_GRAD, v3);
      write_reg(CSR_REST_LEN, v4);
      write_reg(CSR_REST_AMP, v5);
      write_reg(CSR_TILT_AMP, v6);
      write_reg(CSR_DRIVE, v7);
   endtask

   function automatic logic [31:0] plausible_strain();
      return 32'(65536 + $signed($urandom_range(0, 131072)) - 65536);
   endfunction

   task automatic test_field_extremes();
      send(CMD_LOAD, 0, 32'h80000000, 24'h000000);
      send(CMD_LOAD, CELLS - 1, 32'h7fffffff, 24'hffffff);
      send(CMD_LOAD, 170, 32'h00000000, 24'haaaaaa);
      send(CMD_LOAD, 341, 32'hffffffff, 24'h555555);
      send(CMD_READ, 0, 32'h0, 24'h0);
      send(CMD_READ, CELLS - 1, 32'hffffffff, 24'hffffff);
      send(CMD_READ, 170, 32'h0, 24'h0);
      send(CMD_READ, 341, 32'h0, 24'h0);
      // unused command leaves the ring alone
      send(CMD_UNUSED, 0, 32'h12345678, 24'habcdef);
      send(CMD_UNUSED, CELLS - 1, 32'hffffffff, 24'hffffff);
      send(CMD_READ, 0, 32'h0, 24'h0);
      send(CMD_READ, CELLS - 1, 32'h0, 24'h0);
      drain();
   endtask

   task automatic test_fill_ring();
      for (int i = 0; i < CELLS; i++) begin
         send(CMD_LOAD, i, (i % 64 == 0) ? $urandom : plausible_strain(), $urandom);
         tx_gap();
      end
      send(CMD_READ, 511, 0, 0);
      drain();
   endtask

   task automatic test_step_defaults();
      send(CMD_STEP, 0, 0, 0);
      send(CMD_READ, 0, 0, 0);
      send(CMD_READ, 1, 0, 0);
      send(CMD_READ, CELLS - 1, 0, 0);
      send(CMD_STEP, 0, 0, 0);
      send(CMD_READ, 256, 0, 0);
      drain();
   endtask

   task automatic test_config_extremes();
      write_all(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send(CMD_STEP, 0, 0, 0);
      send(CMD_READ, 3, 0, 0);
      send(CMD_READ, 64, 0, 0);
      drain();
      write_all(32'h0, 32'h0, 32'h0, 32'h0,
                32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
      send(CMD_STEP, 0, 0, 0);
      send(CMD_READ, 3, 0, 0);
      send(CMD_READ, 400, 0, 0);
      drain();
   endtask

   // receiver holds off; reads pile up until req_stall holds the sender
   task automatic test_backpressure();
      @(posedge clock);
      hold_left = 300;
      for (int i = 0; i < 12; i++) send(CMD_READ, $urandom_range(CELLS - 1), 0, 0);
      send(CMD_STEP, 0, 0, 0);
      send(CMD_READ, 7, 0, 0);
      drain();
   endtask

   task automatic test_random();
      int p;
      for (int phase_no = 0; phase_no < 4; phase_no++) begin
         if (phase_no == 0)
            write_all(3277, 6554, 32768, 32768, 65536, 32768, 19661, 13107);
         else
            write_all($urandom_range(0, 8000), $urandom_range(0, 20000),
                      $urandom_range(0, 70000), $urandom_range(0, 70000),
                      32'($signed($urandom_range(0, 262144)) - 131072),
                      32'($signed($urandom_range(0, 131072)) - 65536),
                      32'($signed($urandom_range(0, 131072)) - 65536),
                      32'($signed($urandom_range(0, 131072)) - 65536));
         calm_tx = (phase_no == 2);
         calm_rx = (phase_no == 2);
         for (int n = 0; n < 10; n++) begin
            p = $urandom_range(99);
            if (p < 4)
               send(CMD_STEP, $urandom, $urandom, $urandom);
            else if (p < 40)
               send(CMD_LOAD, $urandom_range(CELLS - 1),
                    (p < 8) ? $urandom : plausible_strain(), $urandom);
            else if (p < 94)
               send(CMD_READ, $urandom_range(CELLS - 1), $urandom, $urandom);
            else
               send(CMD_UNUSED, $urandom_range(CELLS - 1), $urandom, $urandom);
            tx_gap();
         end
         settle();
      end
      calm_tx = 1'b0;
      calm_rx = 1'b0;
   endtask

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (calm_rx) begin
         rsp_stall <= 1'b0;
      end else if (rx_run > 0) begin
         rx_run <= rx_run - 1;
      end else begin
         rx_busy = ($urandom_range(99) < 35);
         rsp_stall <= rx_busy;
         rx_run <= ($urandom_range(99) < 92) ? $urandom_range(0, 3) : $urandom_range(10, 50);
      end
   end

   always @(posedge clock) begin
      cell_read_type exp_rd;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            $error("unexpected rsp transaction: cell %0d", rsp_cell_out);
            errors++;
         end else begin
            exp_rd = pending_reads.pop_front();
            if (rsp_cell_out !== exp_rd.cell_no) begin
               $error("cell_out expected %0d actual %0d", exp_rd.cell_no, rsp_cell_out);
               errors++;
            end
            if (rsp_strain_out !== exp_rd.strain) begin
               $error("strain_out expected %0d actual %0d", exp_rd.strain, rsp_strain_out);
               errors++;
            end
            if (rsp_phase_out !== exp_rd.phase) begin
               $error("phase_out expected %h actual %h", exp_rd.phase, rsp_phase_out);
               errors++;
            end
         end
      end
   end

   initial begin
      fill_sine();
      c_dt = 3277; c_mob_l = 6554; c_mob_f = 32768; c_grad = 32768;
      c_rest = 65536; c_ramp = 32768; c_tilt = 19661; c_drive = 13107;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_fill_ring();
      test_step_defaults();
      test_config_extremes();
      test_backpressure();
      test_random();
      drain();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending_reads.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ppfs_pkg.sv
hdl/ppfs_sine_rom.sv
hdl/periodic_phase_field_stencil_step.sv
hdl/ppfs_checker.sv
verif/periodic_phase_field_stencil_step_tb.sv
